[hw/rtl/scs_pkg.sv]
// Shared constants for the shadow call stack tracker.
`default_nettype none

package scs_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;

   localparam int ID_W     = 32;
   localparam int ADDR_W   = 64;
   localparam int STATUS_W = 2;
   localparam int DEPTH_W  = 7;
   localparam int SIG_W    = 64;
   localparam int ENTRY_W  = ID_W + ADDR_W;

   localparam logic KIND_CALL   = 1'b0;
   localparam logic KIND_RETURN = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

endpackage

`default_nettype wire

[hw/rtl/shadow_call_stack_tracker_core.sv]
// Top level of the shadow call stack tracker with a running id signature.
//
//   Channel  Direction  Handshake          Payload
//   req_     in         req_valid/stall    kind, inst_id, address
//   rsp_     out        rsp_valid/stall    status, stack_depth, signature
//
// A call item's result is registered at the accept edge. A return item reads
// one stack entry per cycle from the top downward through the entry RAM,
// examining at most STACK_DEPTH entries. Reset clears the depth and signature;
// RAM contents are not cleared. One item is in work at a time; a new item is
// taken while the last result leaves the output register.
`default_nettype none

module shadow_call_stack_tracker_core #(
   parameter int STACK_DEPTH = scs_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_kind,
   input  wire logic [scs_pkg::ID_W-1:0]      req_inst_id,
   input  wire logic [scs_pkg::ADDR_W-1:0]    req_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [scs_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [scs_pkg::DEPTH_W-1:0]   rsp_stack_depth,
   output logic      [scs_pkg::SIG_W-1:0]     rsp_signature
);

   localparam int AW    = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int EXT_W = (CNT_W > scs_pkg::DEPTH_W) ? CNT_W : scs_pkg::DEPTH_W;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   logic                           state_ff, state_in;
   logic [CNT_W-1:0]               depth_ff, depth_in;
   logic [scs_pkg::SIG_W-1:0]      sig_ff, sig_in;
   logic [AW-1:0]                  level_ff, level_in;
   logic [scs_pkg::SIG_W-1:0]      work_ff, work_in;
   logic [scs_pkg::ADDR_W-1:0]     target_ff, target_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [scs_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]               rsp_depth_ff, rsp_depth_in;
   logic [scs_pkg::SIG_W-1:0]      rsp_sig_ff, rsp_sig_in;

   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [scs_pkg::ENTRY_W-1:0]    wr_data;
   logic                           rd_en;
   logic [AW-1:0]                  rd_addr;
   logic [scs_pkg::ENTRY_W-1:0]    rd_data;
   logic [scs_pkg::ID_W-1:0]       rd_id;
   logic [scs_pkg::ADDR_W-1:0]     rd_ret;

   logic                           req_accept;
   logic [EXT_W-1:0]               depth_ext;

   assign req_stall  = (state_ff == ST_SEARCH) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;

   assign rd_id  = rd_data[scs_pkg::ENTRY_W-1:scs_pkg::ADDR_W];
   assign rd_ret = rd_data[scs_pkg::ADDR_W-1:0];

   scs_ram #(
      .WIDTH(scs_pkg::ENTRY_W),
      .DEPTH(STACK_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      logic [scs_pkg::SIG_W-1:0] work_next;

      work_next     = work_ff - {{(scs_pkg::SIG_W - scs_pkg::ID_W){1'b0}}, rd_id};
      state_in      = state_ff;
      depth_in      = depth_ff;
      sig_in        = sig_ff;
      level_in      = level_ff;
      work_in       = work_ff;
      target_in     = target_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_sig_in    = rsp_sig_ff;
      wr_en         = 1'b0;
      wr_addr       = AW'(depth_ff);
      wr_data       = {req_inst_id, req_address};
      rd_en         = 1'b0;
      rd_addr       = level_ff - 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               if (req_kind == scs_pkg::KIND_CALL) begin
                  if (depth_ff == CNT_W'(STACK_DEPTH)) begin
                     rsp_status_in = scs_pkg::STATUS_FULL;
                     rsp_depth_in  = depth_ff;
                     rsp_sig_in    = sig_ff;
                  end else begin
                     wr_en         = 1'b1;
                     depth_in      = depth_ff + 1'b1;
                     sig_in        = sig_ff +
                        {{(scs_pkg::SIG_W - scs_pkg::ID_W){1'b0}}, req_inst_id};
                     rsp_status_in = scs_pkg::STATUS_OK;
                     rsp_depth_in  = depth_in;
                     rsp_sig_in    = sig_in;
                  end
               end else if (depth_ff == '0) begin
                  rsp_status_in = scs_pkg::STATUS_EMPTY;
                  rsp_depth_in  = depth_ff;
                  rsp_sig_in    = sig_ff;
               end else begin
                  rsp_valid_in = 1'b0;
                  rd_en        = 1'b1;
                  rd_addr      = AW'(depth_ff - 1'b1);
                  level_in     = rd_addr;
                  work_in      = sig_ff;
                  target_in    = req_address;
                  state_in     = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (rd_ret == target_ff) begin
               depth_in      = CNT_W'(level_ff);
               sig_in        = work_next;
               rsp_valid_in  = 1'b1;
               rsp_status_in = scs_pkg::STATUS_OK;
               rsp_depth_in  = CNT_W'(level_ff);
               rsp_sig_in    = work_next;
               state_in      = ST_IDLE;
            end else if (level_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = scs_pkg::STATUS_NOT_FOUND;
               rsp_depth_in  = depth_ff;
               rsp_sig_in    = sig_ff;
               state_in      = ST_IDLE;
            end else begin
               rd_en    = 1'b1;
               level_in = level_ff - 1'b1;
               work_in  = work_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         sig_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         sig_ff       <= sig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      work_ff       <= work_in;
      target_ff     <= target_in;
      rsp_status_ff <= rsp_status_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_sig_ff    <= rsp_sig_in;
   end

   assign depth_ext       = EXT_W'(rsp_depth_ff);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_stack_depth = depth_ext[scs_pkg::DEPTH_W-1:0];
   assign rsp_signature   = rsp_sig_ff;

endmodule

`default_nettype wire

[hw/rtl/scs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module scs_ram #(
   parameter int WIDTH = scs_pkg::ENTRY_W,
   parameter int DEPTH = scs_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
